[hw/rtl/kvlt_pkg.sv]
package kvlt_pkg;

  // Parse phases
  localparam logic [2:0] PH_LINE         = 3'd0;
  localparam logic [2:0] PH_COMMENT      = 3'd1;
  localparam logic [2:0] PH_NAME         = 3'd2;
  localparam logic [2:0] PH_AFTER_NAME   = 3'd3;
  localparam logic [2:0] PH_BEFORE_VALUE = 3'd4;
  localparam logic [2:0] PH_VALUE        = 3'd5;
  localparam logic [2:0] PH_END          = 3'd6;
  localparam logic [2:0] PH_ERROR        = 3'd7;

  // Byte roles
  localparam logic [2:0] ROLE_SKIP    = 3'd0;
  localparam logic [2:0] ROLE_COMMENT = 3'd1;
  localparam logic [2:0] ROLE_NAME    = 3'd2;
  localparam logic [2:0] ROLE_VALUE   = 3'd3;
  localparam logic [2:0] ROLE_IGNORED = 3'd4;

  // Stop status
  localparam logic [1:0] STOP_RUN = 2'd0;
  localparam logic [1:0] STOP_END = 2'd1;
  localparam logic [1:0] STOP_ERR = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_A     = 8'h41;

  // Outcome of one parse step
  typedef struct packed {
    logic [2:0] next_phase;
    logic [2:0] role;
    logic       done;
    logic [1:0] stop;
  } kvlt_step_t;

endpackage

[hw/rtl/kvlt_classify.sv]
module kvlt_classify import kvlt_pkg::*; (
  input  logic [2:0] phase,
  input  logic [7:0] text_byte,
  input  logic       restart,
  input  logic       high_bytes_signed,
  output kvlt_step_t step
);

  logic       neg;
  logic       is_nul;
  logic       is_space;
  logic       is_eol;
  logic       is_eq;
  logic       below_a;
  logic       is_name;
  logic [2:0] cur;
  logic [2:0] nxt;
  logic [2:0] role;
  logic       done;

  // Byte classes; a negative char (signed mode) is below 'A' and never space
  assign neg      = high_bytes_signed & text_byte[7];
  assign is_nul   = (text_byte == CH_NUL);
  assign is_space = !is_nul && (text_byte <= CH_SPACE);
  assign is_eol   = (text_byte == CH_CR) || (text_byte == CH_LF);
  assign is_eq    = (text_byte == CH_EQ);
  assign below_a  = neg || (text_byte < CH_A);
  assign is_name  = !below_a || ((text_byte >= CH_ZERO) && (text_byte <= CH_NINE));

  assign cur = restart ? PH_LINE : phase;

  // Phase transition
  always_comb begin
    nxt  = cur;
    role = ROLE_SKIP;
    done = 1'b0;
    unique case (cur)
      PH_LINE: begin
        if (is_nul) nxt = PH_END;
        else if (is_space) nxt = PH_LINE;
        else if (below_a) begin
          role = ROLE_COMMENT;
          nxt  = PH_COMMENT;
        end else begin
          role = ROLE_NAME;
          nxt  = PH_NAME;
        end
      end
      PH_COMMENT: begin
        if (is_nul) nxt = PH_END;
        else if (is_eol) nxt = PH_LINE;
        else role = ROLE_COMMENT;
      end
      PH_NAME: begin
        if (is_name) role = ROLE_NAME;
        else if (is_nul) nxt = PH_END;
        else if (is_space) nxt = PH_AFTER_NAME;
        else if (is_eq) nxt = PH_BEFORE_VALUE;
        else nxt = PH_ERROR;
      end
      PH_AFTER_NAME: begin
        if (is_space) nxt = PH_AFTER_NAME;
        else if (is_eq) nxt = PH_BEFORE_VALUE;
        else nxt = PH_ERROR;
      end
      PH_BEFORE_VALUE: begin
        if (is_nul) nxt = PH_END;
        else if (is_eol) begin
          done = 1'b1;
          nxt  = PH_LINE;
        end else if (is_space && (text_byte != CH_BEL)) nxt = PH_BEFORE_VALUE;
        else begin
          role = ROLE_VALUE;
          nxt  = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (is_nul) begin
          done = 1'b1;
          nxt  = PH_END;
        end else if (is_eol) begin
          done = 1'b1;
          nxt  = PH_LINE;
        end else role = ROLE_VALUE;
      end
      default: begin
        // stopped at end or on error
        role = ROLE_IGNORED;
      end
    endcase
  end

  assign step.next_phase = nxt;
  assign step.role       = role;
  assign step.done       = done;
  assign step.stop       = (nxt == PH_END) ? STOP_END :
                           (nxt == PH_ERROR) ? STOP_ERR : STOP_RUN;

endmodule

[hw/rtl/key_value_line_tokenizer.sv]
// Key/value line tokenizer: tags each text byte of a config file.
// Input channel in_*: one request per text byte; in_tdata holds the byte,
// in_tuser bit 0 restarts parsing at line start on this byte.
// Result channel out_*: one request per input byte; out_tdata echoes the
// byte, out_tuser carries the byte role and stop status, out_tlast marks
// the byte that closes a name/value pair.
// Config: cfg_we writes cfg_wdata into the signed-high-bytes flag; write
// it only while no byte is in flight.
// Path: a byte is held in the input stage register, then in the result register.
// One byte per cycle while the result is not stalled; the parse phase register updates in the
// same cycle as the result register, so each byte sees its predecessor.
// Reset (rst_n low, synchronous): both stages empty, phase at line start,
// signed-high-bytes flag set.
// Stall: when out_tready is low the result holds, the input stage holds
// one more byte, and in_tready drops once both are full.
module key_value_line_tokenizer import kvlt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tuser,   // [0] restart
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] byte_out
  output logic [4:0] out_tuser,  // [2:0] byte_role, [4:3] stop_code
  output logic       out_tlast,  // pair_done
  input  logic       cfg_we,
  input  logic       cfg_wdata   // high_bytes_signed
);

  logic       cfg_signed_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_restart_r;
  logic [2:0] phase_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [2:0] out_role_r;
  logic       out_done_r;
  logic [1:0] out_stop_r;
  logic       s1_adv;
  logic       in_acc;
  kvlt_step_t step;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_signed_r <= 1'b1;
    end else if (cfg_we) begin
      cfg_signed_r <= cfg_wdata;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r    <= in_tdata;
      s1_restart_r <= in_tuser;
    end
  end

  kvlt_classify u_classify (
    .phase             (phase_r),
    .text_byte         (s1_byte_r),
    .restart           (s1_restart_r),
    .high_bytes_signed (cfg_signed_r),
    .step              (step)
  );

  // Phase and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINE;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        phase_r <= step.next_phase;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= s1_byte_r;
      out_role_r <= step.role;
      out_done_r <= step.done;
      out_stop_r <= step.stop;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_stop_r, out_role_r};
  assign out_tlast  = out_done_r;

`ifndef ASSERT_OFF
  // A closing byte is always a terminator, tagged skipped
  a_done_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_role_r == ROLE_SKIP)
    else $error("pair_done on a non-skipped byte");

  // Ignored bytes only come while stopped
  a_ignored_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_role_r == ROLE_IGNORED) |-> out_stop_r != STOP_RUN)
    else $error("ignored byte while running");

  // Reset returns the parser to line start
  a_reset_phase: assert property (@(posedge clk)
    !rst_n |=> phase_r == PH_LINE)
    else $error("phase not at line start after reset");

  // Phase moves only when a byte goes into the result register
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(phase_r))
    else $error("phase changed without a byte");

  // Every advanced byte produces a result
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced byte lost");
`endif

endmodule
